// ----- rtl/kssd_pkg.sv -----
// Package for the keyed 2x2 supersample downscaler.
// Holds widths, register indexes, reset values, the subpixel block type and
// the coverage and divide-by-three helpers. No dependencies.
package kssd_pkg;

  localparam int COLOR_W   = 24;
  localparam int CH_W      = 8;
  localparam int NUM_CH    = 3;
  localparam int NUM_SUB   = 4;
  localparam int SUM_W     = 10;  // 4 * 255 fits
  localparam int CNT_W     = 3;   // 0..4 foreground subpixels
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_COLOR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_COLOR = 2'd1;

  localparam logic [COLOR_W-1:0] KEY_RESET  = 24'h505050;
  localparam logic [COLOR_W-1:0] FILL_RESET = 24'hC0E080;

  localparam logic [CH_W-1:0] ALPHA_NONE  = 8'd0;
  localparam logic [CH_W-1:0] ALPHA_ONE   = 8'd64;
  localparam logic [CH_W-1:0] ALPHA_TWO   = 8'd128;
  localparam logic [CH_W-1:0] ALPHA_THREE = 8'd192;
  localparam logic [CH_W-1:0] ALPHA_FULL  = 8'd255;

  // s / 3 == (s * 683) >> 11 for every s below 3 * 256
  localparam int DIV3_RECIP = 683;
  localparam int DIV3_SHIFT = 11;
  localparam int DIV3_PROD_W = SUM_W + 9;

  typedef struct packed {
    logic [COLOR_W-1:0] top_left;
    logic [COLOR_W-1:0] top_right;
    logic [COLOR_W-1:0] bottom_left;
    logic [COLOR_W-1:0] bottom_right;
  } block_t;

  function automatic logic [CH_W-1:0] coverage_of(input logic [CNT_W-1:0] cnt);
    logic [CH_W-1:0] alpha;
    unique case (cnt)
      3'd0:    alpha = ALPHA_NONE;
      3'd1:    alpha = ALPHA_ONE;
      3'd2:    alpha = ALPHA_TWO;
      3'd3:    alpha = ALPHA_THREE;
      default: alpha = ALPHA_FULL;
    endcase
    return alpha;
  endfunction

  function automatic logic [CH_W-1:0] div3(input logic [SUM_W-1:0] s);
    logic [DIV3_PROD_W-1:0] prod;
    prod = DIV3_PROD_W'(s) * DIV3_PROD_W'(DIV3_RECIP);
    return prod[DIV3_SHIFT +: CH_W];
  endfunction

endpackage

// ----- rtl/kssd_core.sv -----
// Averaging datapath and result register of the keyed 2x2 downscaler.
// Takes one registered block per cycle; depends on kssd_pkg.
module kssd_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         blk_vld,
  input  kssd_pkg::block_t             blk,
  input  logic [kssd_pkg::COLOR_W-1:0] key_color,
  input  logic [kssd_pkg::COLOR_W-1:0] fill_color,
  output logic                         res_vld,
  output logic [kssd_pkg::COLOR_W-1:0] res_color,
  output logic [kssd_pkg::CH_W-1:0]    res_coverage
);
  import kssd_pkg::*;

  logic [NUM_SUB-1:0][COLOR_W-1:0] px;
  logic [NUM_SUB-1:0]              fg;
  logic [CNT_W-1:0]                cnt;
  logic [NUM_CH-1:0][SUM_W-1:0]    sum;
  logic [NUM_CH-1:0][CH_W-1:0]     avg;
  logic [COLOR_W-1:0]              color_nxt;

  logic                res_vld_r;
  logic [COLOR_W-1:0]  color_r;
  logic [CH_W-1:0]     coverage_r;

  assign px = {blk.top_left, blk.top_right, blk.bottom_left, blk.bottom_right};

  always_comb begin
    cnt = '0;
    sum = '0;
    for (int k = 0; k < NUM_SUB; k++) begin
      fg[k] = (px[k] != key_color);
      if (fg[k]) begin
        cnt = cnt + CNT_W'(1);
        for (int c = 0; c < NUM_CH; c++) begin
          sum[c] = sum[c] + SUM_W'(px[k][CH_W*c +: CH_W]);
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      unique case (cnt)
        3'd1:    avg[c] = sum[c][CH_W-1:0];
        3'd2:    avg[c] = sum[c][CH_W:1];
        3'd3:    avg[c] = div3(sum[c]);
        3'd4:    avg[c] = sum[c][CH_W+1:2];
        default: avg[c] = '0;
      endcase
    end
    color_nxt = (cnt == '0) ? fill_color : avg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else begin
      res_vld_r <= blk_vld;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    color_r    <= color_nxt;
    coverage_r <= coverage_of(cnt);
  end

  assign res_vld      = res_vld_r;
  assign res_color    = color_r;
  assign res_coverage = coverage_r;

  a_vld_follows : assert property (@(posedge clk) disable iff (!rst_n)
    blk_vld |=> res_vld)
    else $error("kssd_core: block beat did not produce a result");

  a_no_phantom : assert property (@(posedge clk) disable iff (!rst_n)
    !blk_vld |=> !res_vld)
    else $error("kssd_core: result without a block beat");

  a_cov_legal : assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |-> (res_coverage == ALPHA_NONE || res_coverage == ALPHA_ONE ||
                 res_coverage == ALPHA_TWO || res_coverage == ALPHA_THREE ||
                 res_coverage == ALPHA_FULL))
    else $error("kssd_core: illegal coverage value");

  a_all_key : assert property (@(posedge clk) disable iff (!rst_n)
    (blk_vld && blk.top_left == key_color && blk.top_right == key_color &&
     blk.bottom_left == key_color && blk.bottom_right == key_color)
    |=> (res_coverage == ALPHA_NONE))
    else $error("kssd_core: all-key block gave nonzero coverage");

endmodule

// ----- rtl/keyed_supersample_downscale.sv -----
// Top level of the keyed 2x2 supersample downscaler: config registers,
// input register and the averaging core. Depends on kssd_pkg and kssd_core.
//
//   channel   direction  handshake           payload
//   in        in         start / busy        in_sub_* (4 x 24 bits)
//   out       out        out_valid (strobe)  out_pixel_color, out_coverage
//   cfg       in         cfg_we              cfg_index, cfg_data
//
// One pixel per clock: a beat is taken every cycle (busy stays low).
// The path runs through the input register, then the average/select logic into
// the result register. A result shows for one cycle with out_valid.
// Reset (rst_n low, synchronous) clears the valid pipeline and loads the
// key and fill colors with their defaults. The receiver cannot stall.
module keyed_supersample_downscale (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [kssd_pkg::COLOR_W-1:0]   in_sub_top_left,
  input  logic [kssd_pkg::COLOR_W-1:0]   in_sub_top_right,
  input  logic [kssd_pkg::COLOR_W-1:0]   in_sub_bottom_left,
  input  logic [kssd_pkg::COLOR_W-1:0]   in_sub_bottom_right,
  output logic                           out_valid,
  output logic [kssd_pkg::COLOR_W-1:0]   out_pixel_color,
  output logic [kssd_pkg::CH_W-1:0]      out_coverage,
  input  logic                           cfg_we,
  input  logic [kssd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kssd_pkg::COLOR_W-1:0]   cfg_data
);
  import kssd_pkg::*;

  logic [COLOR_W-1:0] key_color_r;
  logic [COLOR_W-1:0] fill_color_r;
  logic               in_vld_r;
  block_t             blk_r;
  logic               accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // indexes past the register list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_color_r  <= KEY_RESET;
      fill_color_r <= FILL_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_KEY_COLOR) begin
        key_color_r <= cfg_data;
      end
      if (cfg_index == CFG_FILL_COLOR) begin
        fill_color_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      blk_r.top_left     <= in_sub_top_left;
      blk_r.top_right    <= in_sub_top_right;
      blk_r.bottom_left  <= in_sub_bottom_left;
      blk_r.bottom_right <= in_sub_bottom_right;
    end
  end

  kssd_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .blk_vld      (in_vld_r),
    .blk          (blk_r),
    .key_color    (key_color_r),
    .fill_color   (fill_color_r),
    .res_vld      (out_valid),
    .res_color    (out_pixel_color),
    .res_coverage (out_coverage)
  );

endmodule
